[rtl/pe_pkg.sv]
// Package with the shared constants, types and fixed-point helpers of the polynomial evaluator.
`timescale 1ns / 1ps

package pe_pkg;

	localparam int DEGREE      = 7;
	localparam int FRAC_BITS   = 16;
	localparam int NUM_COEFFS  = 8;
	localparam int DATA_W      = 32;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int COEFF_IDX_W = $clog2(NUM_COEFFS);
	localparam int CFG_IDX_W   = COEFF_IDX_W + 1;
	localparam int IN_TDATA_W  = ((DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_W + 1 + 7) / 8) * 8;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		word_t val;
		logic  ovf;
	} sat_t;

	localparam prod_t SAT_MAX = {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam prod_t SAT_MIN = ~SAT_MAX;

	// Floor shift of a full product back to the word format, then saturation.
	function automatic sat_t qtrunc(input prod_t p);
		prod_t s;
		sat_t  r;
		s = p >>> FRAC_BITS;
		if (s > SAT_MAX) begin
			r.val = SAT_MAX[DATA_W-1:0];
			r.ovf = 1'b1;
		end else if (s < SAT_MIN) begin
			r.val = SAT_MIN[DATA_W-1:0];
			r.ovf = 1'b1;
		end else begin
			r.val = s[DATA_W-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

	// Saturating add of two words.
	function automatic sat_t sat_add(input word_t a, input word_t b);
		logic signed [DATA_W:0] s;
		sat_t                   r;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		if (s[DATA_W] != s[DATA_W-1]) begin
			r.val = s[DATA_W] ? SAT_MIN[DATA_W-1:0] : SAT_MAX[DATA_W-1:0];
			r.ovf = 1'b1;
		end else begin
			r.val = s[DATA_W-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

endpackage

[rtl/polynomial_evaluator_top.sv]
// Top level of the pipelined power-series polynomial evaluator.
`timescale 1ns / 1ps

// The block evaluates c0 + c1*x + ... + c7*x^7 for each signed Q16.16 sample
// x, in Q16.16, with every product floored to Q16.16 and every product and
// sum saturated to 32 bits; bit 32 of the result item flags any saturation.
// It is a pipeline of 15 register stages: one entry stage that loads x and
// c0, then for each term a multiply stage (coefficient times running power
// and running power times x, two 32x32 multipliers side by side) followed
// by a truncate-and-accumulate stage. While the output is not stalled, an
// item can enter in every cycle, so the sustained rate is one item per
// clock. Each stage holds its item while the next one is full and stalled,
// so back-pressure on the output never drops or repeats an item and empty
// stages still fill up behind a waiting result. The user must write the
// coefficients through the cfg port only while no item is in flight; the
// block does not enforce this. An index of 8 or above is ignored.
module polynomial_evaluator_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [pe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pe_pkg::DATA_W-1:0]        cfg_data,
	// Sample stream; tdata: sample_x [31:0].
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [pe_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// Result stream; tdata: poly_value [31:0], overflow [32], zero fill above.
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [pe_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import pe_pkg::*;

	// Coefficient registers.
	word_t coeff_q [NUM_COEFFS];

	// Accumulate stages 0..DEGREE; stage 0 is the entry stage.
	logic  vld_add_s [DEGREE+1];
	word_t x_add_s   [DEGREE+1];
	word_t pw_add_s  [DEGREE+1];
	word_t sum_add_s [DEGREE+1];
	logic  ovf_add_s [DEGREE+1];

	// Multiply stages 1..DEGREE.
	logic  vld_mul_s  [1:DEGREE];
	word_t x_mul_s    [1:DEGREE];
	word_t sum_mul_s  [1:DEGREE];
	logic  ovf_mul_s  [1:DEGREE];
	prod_t term_mul_s [1:DEGREE];
	prod_t pwp_mul_s  [1:DEGREE];

	// Load enables: a stage may load when it is empty or its item moves on.
	logic en_add [DEGREE+1];
	logic en_mul [1:DEGREE];

	always_comb begin
		en_add[DEGREE] = !vld_add_s[DEGREE] || m_axis_tready;
		for (int i = DEGREE; i >= 1; i--) begin
			en_mul[i]   = !vld_mul_s[i] || en_add[i];
			en_add[i-1] = !vld_add_s[i-1] || en_mul[i];
		end
	end

	assign s_axis_tready = en_add[0];

	// Coefficient writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFFS; i++) begin
				coeff_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_COEFFS))) begin
			coeff_q[cfg_index[COEFF_IDX_W-1:0]] <= cfg_data;
		end
	end

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DEGREE; i++) begin
				vld_add_s[i] <= 1'b0;
			end
			for (int i = 1; i <= DEGREE; i++) begin
				vld_mul_s[i] <= 1'b0;
			end
		end else begin
			if (en_add[0]) begin
				vld_add_s[0] <= s_axis_tvalid;
			end
			for (int i = 1; i <= DEGREE; i++) begin
				if (en_mul[i]) begin
					vld_mul_s[i] <= vld_add_s[i-1];
				end
				if (en_add[i]) begin
					vld_add_s[i] <= vld_mul_s[i];
				end
			end
		end
	end

	// Truncated products and new sums entering each accumulate stage.
	sat_t term_q16 [1:DEGREE];
	sat_t pw_q16   [1:DEGREE];
	sat_t sum_next [1:DEGREE];

	always_comb begin
		for (int i = 1; i <= DEGREE; i++) begin
			term_q16[i] = qtrunc(term_mul_s[i]);
			pw_q16[i]   = qtrunc(pwp_mul_s[i]);
			sum_next[i] = sat_add(sum_mul_s[i], term_q16[i].val);
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en_add[0]) begin
			x_add_s[0]   <= s_axis_tdata[DATA_W-1:0];
			pw_add_s[0]  <= s_axis_tdata[DATA_W-1:0];
			sum_add_s[0] <= coeff_q[0];
			ovf_add_s[0] <= 1'b0;
		end
		for (int i = 1; i <= DEGREE; i++) begin
			if (en_mul[i]) begin
				x_mul_s[i]    <= x_add_s[i-1];
				sum_mul_s[i]  <= sum_add_s[i-1];
				ovf_mul_s[i]  <= ovf_add_s[i-1];
				term_mul_s[i] <= PROD_W'(coeff_q[i]) * PROD_W'(pw_add_s[i-1]);
				// The power past the last term is never formed.
				if (i < DEGREE) begin
					pwp_mul_s[i] <= PROD_W'(pw_add_s[i-1]) * PROD_W'(x_add_s[i-1]);
				end else begin
					pwp_mul_s[i] <= '0;
				end
			end
			if (en_add[i]) begin
				x_add_s[i]   <= x_mul_s[i];
				pw_add_s[i]  <= pw_q16[i].val;
				sum_add_s[i] <= sum_next[i].val;
				ovf_add_s[i] <= ovf_mul_s[i] | term_q16[i].ovf | sum_next[i].ovf
				                | ((i < DEGREE) ? pw_q16[i].ovf : 1'b0);
			end
		end
	end

	assign m_axis_tvalid = vld_add_s[DEGREE];
	assign m_axis_tdata  = {{(OUT_TDATA_W-DATA_W-1){1'b0}}, ovf_add_s[DEGREE],
	                        sum_add_s[DEGREE]};

endmodule

[test/polynomial_evaluator_top_tb.sv]
// Self-checking testbench for the pipelined polynomial evaluator.
`timescale 1ns / 1ps

// Keeps the coefficient copy, predicts each result and compares the stream.
class poly_scoreboard;
	typedef struct {
		pe_pkg::word_t sample;
		pe_pkg::word_t value;
		bit            ovf;
	} poly_result_t;

	pe_pkg::word_t coeff [pe_pkg::NUM_COEFFS];
	poly_result_t  awaited [$];
	int            n_samples;
	int            n_checked;
	int            n_saturated;
	int            n_errors;

	function new();
		foreach (coeff[i]) coeff[i] = '0;
		n_samples   = 0;
		n_checked   = 0;
		n_saturated = 0;
		n_errors    = 0;
	endfunction

	function void write_coeff(input int unsigned idx, input logic [pe_pkg::DATA_W-1:0] data);
		// Indexes past the last coefficient are dropped by the block.
		if (idx < pe_pkg::NUM_COEFFS) coeff[idx] = data;
	endfunction

	// Clamp a wide value into the signed 32-bit range.
	function pe_pkg::word_t clamp_word(input logic signed [63:0] v, inout bit ovf);
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			ovf = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sh0000_0000_8000_0000) begin
			ovf = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Full product, floored back to the word format, then clamped.
	function pe_pkg::word_t fx_mul(input pe_pkg::word_t a, input pe_pkg::word_t b, inout bit ovf);
		logic signed [63:0] wa;
		logic signed [63:0] wb;
		wa = a;
		wb = b;
		return clamp_word((wa * wb) >>> pe_pkg::FRAC_BITS, ovf);
	endfunction

	function void note_sample(input pe_pkg::word_t x);
		poly_result_t       r;
		pe_pkg::word_t      power;
		pe_pkg::word_t      term;
		logic signed [63:0] acc;
		bit                 ovf;
		ovf   = 1'b0;
		power = x;
		r.sample = x;
		r.value  = coeff[0];
		for (int i = 1; i <= pe_pkg::DEGREE; i++) begin
			term = fx_mul(coeff[i], power, ovf);
			acc  = r.value;
			acc  = acc + term;
			r.value = clamp_word(acc, ovf);
			// The power past the last term is never formed.
			if (i < pe_pkg::DEGREE) power = fx_mul(power, x, ovf);
		end
		r.ovf = ovf;
		awaited.push_back(r);
		n_samples++;
	endfunction

	function void check_result(input logic [pe_pkg::OUT_TDATA_W-1:0] d);
		poly_result_t r;
		bit           bad;
		n_checked++;
		if (awaited.size() == 0) begin
			n_errors++;
			if (n_errors <= 10) $display("ERROR: result %h arrived with no sample outstanding", d);
			return;
		end
		r = awaited.pop_front();
		if (r.ovf) n_saturated++;
		bad = (d[pe_pkg::DATA_W-1:0] !== r.value) || (d[pe_pkg::DATA_W] !== r.ovf) ||
			(d[pe_pkg::OUT_TDATA_W-1:pe_pkg::DATA_W+1] !== '0);
		if (bad) begin
			n_errors++;
			if (n_errors <= 10)
				$display("ERROR: x=%h expected value %h overflow %0b, got value %h overflow %0b fill %h",
					r.sample, r.value, r.ovf, d[pe_pkg::DATA_W-1:0], d[pe_pkg::DATA_W],
					d[pe_pkg::OUT_TDATA_W-1:pe_pkg::DATA_W+1]);
		end
	endfunction

	function int pending();
		return awaited.size();
	endfunction
endclass

module polynomial_evaluator_top_tb;
	import pe_pkg::*;

	// Pipeline depth in register stages, as the block's header gives it.
	localparam int LATENCY     = 15;
	localparam int N_PHASES    = 10;
	localparam int PHASE_ITEMS = 112;

	localparam word_t Q_ONE = 32'sh0001_0000;
	localparam word_t Q_MAX = 32'sh7FFF_FFFF;
	localparam word_t Q_MIN = 32'sh8000_0000;

	// Coefficient set styles used by the random phases.
	typedef enum int {
		SET_SMALL,
		SET_FULL,
		SET_LOW_DEGREE,
		SET_EXTREME,
		SET_MIXED
	} coeff_style_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [DATA_W-1:0]      cfg_data  = '0;
	logic                   s_valid   = 1'b0;
	logic [IN_TDATA_W-1:0]  s_data    = '0;
	logic                   m_ready   = 1'b0;
	logic                   s_axis_tready;
	logic                   m_axis_tvalid;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	poly_scoreboard sb = new();

	// Chance in percent of an idle burst on each side; changed per phase.
	int gap_pct    = 0;
	int stall_pct  = 0;
	int stall_left = 0;
	int n_sets     = 0;

	polynomial_evaluator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Safety net: the slowest legal run is far below this.
	initial begin
		#5_000_000;
		$display("ERROR: timeout with %0d results still outstanding", sb.pending());
		$display("end of test: mismatches");
		$finish;
	end

	// Result side. Every item taken at an edge is checked against the oldest
	// prediction; tready then goes low in random bursts.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_ready) sb.check_result(m_axis_tdata);
			if (stall_left > 0) begin
				stall_left--;
				m_ready <= 1'b0;
			end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 5);
				m_ready <= 1'b0;
			end else begin
				m_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input int unsigned idx, input logic [DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx[CFG_IDX_W-1:0];
		cfg_data  <= data;
		@(posedge clk);
		sb.write_coeff(idx, data);
	endtask

	// Writes all coefficients back to back. With add_junk set, a write to an
	// index past the coefficient file follows, which must change nothing.
	task automatic load_coeffs(input word_t c [NUM_COEFFS], input bit add_junk);
		for (int i = 0; i < NUM_COEFFS; i++) write_reg(i, c[i]);
		if (add_junk) write_reg($urandom_range(NUM_COEFFS, 2**CFG_IDX_W - 1), $urandom);
		cfg_we <= 1'b0;
		n_sets++;
	endtask

	// Offers one sample, possibly after an idle burst, and holds it until taken.
	// tvalid stays high when the next sample follows without a gap.
	task automatic send_sample(input word_t x);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			s_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_data  <= x;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(x);
	endtask

	// Stops offering samples and waits until every predicted result is in.
	// Every sample yields a result, so an empty queue means an empty pipeline.
	task automatic wait_results_done();
		s_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Samples mostly near the unit range so that results stay in range often,
	// with full-range values and the edge values mixed in.
	function automatic word_t rand_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return int'($urandom_range(0, 262144)) - 131072;
			4, 5:       return int'($urandom_range(0, 2097152)) - 1048576;
			6, 7:       return $urandom;
			8: begin
				case ($urandom_range(0, 6))
					0:       return Q_MAX;
					1:       return Q_MIN;
					2:       return '0;
					3:       return Q_ONE;
					4:       return -Q_ONE;
					5:       return 32'sh0000_0001;
					default: return -32'sh0000_0001;
				endcase
			end
			default: return int'($urandom_range(0, 131070)) - 65535;
		endcase
	endfunction

	function automatic word_t rand_coeff(input coeff_style_t style);
		case (style)
			SET_FULL: return $urandom;
			SET_EXTREME: begin
				case ($urandom_range(0, 4))
					0:       return Q_MAX;
					1:       return Q_MIN;
					2:       return '0;
					3:       return Q_ONE;
					default: return -Q_ONE;
				endcase
			end
			default: return int'($urandom_range(0, 524288)) - 262144;
		endcase
	endfunction

	initial begin
		word_t        c [NUM_COEFFS];
		coeff_style_t style;
		int           top_term;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with light idling on both sides.
		gap_pct   = 20;
		stall_pct = 20;

		// Coefficients still at reset: the value is zero, but the running power
		// saturates for the extreme samples and must still raise the flag.
		send_sample('0);
		send_sample(Q_MAX);
		send_sample(Q_MIN);
		wait_results_done();

		// All coefficients 1.0: unit points, halves, doubles and the smallest
		// step on either side, where the floor of a negative product shows.
		foreach (c[i]) c[i] = Q_ONE;
		load_coeffs(c, 1'b0);
		send_sample('0);
		send_sample(Q_ONE);
		send_sample(-Q_ONE);
		send_sample(32'sh0000_8000);
		send_sample(-32'sh0000_0001);
		send_sample(32'sh0000_0001);
		send_sample(32'sh0002_0000);
		send_sample(-32'sh0002_0000);
		wait_results_done();

		// Largest and smallest coefficients against the extremes of x.
		foreach (c[i]) c[i] = Q_MAX;
		load_coeffs(c, 1'b0);
		send_sample('0);
		send_sample(Q_ONE);
		send_sample(-Q_ONE);
		send_sample(Q_MAX);
		send_sample(Q_MIN);
		wait_results_done();
		foreach (c[i]) c[i] = Q_MIN;
		load_coeffs(c, 1'b0);
		send_sample('0);
		send_sample(Q_ONE);
		send_sample(-Q_ONE);
		send_sample(Q_MAX);
		send_sample(Q_MIN);
		wait_results_done();

		// A first-degree polynomial made by zeroing the rest, plus a write to an
		// index past the file. At x = 256.0 the square already saturates, so the
		// flag is set although the value itself is just x.
		c = '{default: '0};
		c[1] = Q_ONE;
		load_coeffs(c, 1'b1);
		send_sample(32'sh0100_0000);
		send_sample(32'sh0002_0000);
		wait_results_done();

		// Only the highest term: x to the seventh.
		c = '{default: '0};
		c[DEGREE] = Q_ONE;
		load_coeffs(c, 1'b0);
		send_sample(32'sh0002_0000);
		send_sample(-32'sh0002_0000);

		// Random part: one coefficient set per phase, cycling through the styles.
		for (int p = 0; p < N_PHASES; p++) begin
			wait_results_done();
			style = coeff_style_t'(p % 5);
			top_term = $urandom_range(1, DEGREE - 1);
			foreach (c[i]) begin
				case (style)
					SET_LOW_DEGREE: c[i] = (i <= top_term) ? rand_coeff(SET_SMALL) : '0;
					SET_MIXED:      c[i] = rand_coeff(coeff_style_t'($urandom_range(0, 3)));
					default:        c[i] = rand_coeff(style);
				endcase
			end
			load_coeffs(c, style == SET_LOW_DEGREE || style == SET_MIXED);

			// The last phase runs at full rate with no idling on either side.
			if (p == N_PHASES - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = 20 * $urandom_range(0, 2);
				stall_pct = 20 * $urandom_range(0, 2);
			end

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Once in the run, let the pipeline empty out completely mid-phase.
				if (p == 3 && k == PHASE_ITEMS / 2) wait_results_done();
				send_sample(rand_sample());
			end
		end

		wait_results_done();
		// Give any stray extra result time to show up.
		repeat (2 * LATENCY) @(posedge clk);

		$display("Run covered %0d samples under %0d coefficient sets, from zero through the extremes.",
			sb.n_samples, n_sets);
		$display("%0d results checked, %0d of them saturated, %0d mismatches.",
			sb.n_checked, sb.n_saturated, sb.n_errors);
		if (sb.n_errors == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
